// ===== hdl/psw_pkg.sv =====
// ---------------------------------------------------------------------------
// psw_pkg
// Shared constants and types for the two-pointer pair-sum block.
// ---------------------------------------------------------------------------
package psw_pkg;

   localparam int MAX_SET = 1024;
   localparam int ADDR_W  = $clog2(MAX_SET);
   localparam int SIZE_W  = ADDR_W + 1;
   localparam int DATA_W  = 32;

   localparam logic [SIZE_W-1:0] MAX_SIZE = SIZE_W'(MAX_SET);

   // request kinds, carried on req_tuser
   localparam logic [1:0] KIND_LOAD_FIRST  = 2'd0;
   localparam logic [1:0] KIND_LOAD_SECOND = 2'd1;
   localparam logic [1:0] KIND_QUERY       = 2'd2;

   // query start from the front end to the walk engine
   typedef struct packed {
      logic                     start;
      logic signed [DATA_W-1:0] target;
      logic [SIZE_W-1:0]        size;    // already clamped to MAX_SET
   } query_type;

endpackage

// ===== hdl/psw_ram.sv =====
// ---------------------------------------------------------------------------
// psw_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ---------------------------------------------------------------------------
module psw_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/psw_walk.sv =====
// ---------------------------------------------------------------------------
// psw_walk
// Two-pointer walk engine: drives both RAM read ports, one pointer step per
// cycle, and holds the result register of the response channel.
// ---------------------------------------------------------------------------
module psw_walk (
   input  logic                              clock,
   input  logic                              reset,
   input  psw_pkg::query_type                query,
   output logic                              busy,
   output logic [psw_pkg::ADDR_W-1:0]        first_rd_addr,
   input  logic [psw_pkg::DATA_W-1:0]        first_rd_data,
   output logic [psw_pkg::ADDR_W-1:0]        second_rd_addr,
   input  logic [psw_pkg::DATA_W-1:0]        second_rd_data,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic                              rsp_found,
   output logic [psw_pkg::DATA_W-1:0]        rsp_first,
   output logic [psw_pkg::DATA_W-1:0]        rsp_second
);
   import psw_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_LOAD,
      S_WALK,
      S_EMIT
   } state_type;

   state_type         state_ff, state_in;
   logic [SIZE_W-1:0] i_ff, i_in;       // first-set pointer
   logic [SIZE_W-1:0] j_ff, j_in;       // one past the second-set pointer
   logic [SIZE_W-1:0] n_ff, n_in;
   logic [DATA_W-1:0] target_ff, target_in;
   logic [DATA_W-1:0] a_ff, a_in;       // first_set[i]
   logic [DATA_W-1:0] b_ff, b_in;       // second_set[j-1]
   logic              res_found_ff, res_found_in;
   logic [DATA_W-1:0] res_a_ff, res_a_in;
   logic [DATA_W-1:0] res_b_ff, res_b_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_found_ff, rsp_found_in;
   logic [DATA_W-1:0] rsp_first_ff, rsp_first_in;
   logic [DATA_W-1:0] rsp_second_ff, rsp_second_in;

   logic signed [DATA_W:0] sum;
   logic signed [DATA_W:0] target_x;
   logic [SIZE_W-1:0]      i_inc;
   logic [SIZE_W-1:0]      j_dec;
   logic [SIZE_W-1:0]      rd1_ptr;
   logic [SIZE_W-1:0]      rd2_ptr;

   assign sum      = $signed({a_ff[DATA_W-1], a_ff}) + $signed({b_ff[DATA_W-1], b_ff});
   assign target_x = $signed({target_ff[DATA_W-1], target_ff});
   assign i_inc    = i_ff + SIZE_W'(1);
   assign j_dec    = j_ff - SIZE_W'(1);

   always_comb begin
      state_in      = state_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      n_in          = n_ff;
      target_in     = target_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      res_found_in  = res_found_ff;
      res_a_in      = res_a_ff;
      res_b_in      = res_b_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_tready;
      rsp_found_in  = rsp_found_ff;
      rsp_first_in  = rsp_first_ff;
      rsp_second_in = rsp_second_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (query.start) begin
               i_in      = '0;
               j_in      = query.size;
               n_in      = query.size;
               target_in = query.target;
               if (query.size == '0) begin
                  res_found_in = 1'b0;
                  res_a_in     = '0;
                  res_b_in     = '0;
                  state_in     = S_EMIT;
               end else begin
                  state_in = S_LOAD;
               end
            end
         end
         S_LOAD: begin
            a_in     = first_rd_data;
            b_in     = second_rd_data;
            state_in = S_WALK;
         end
         S_WALK: begin
            // RAMs hold first_set[i+1] and second_set[j-2] here, so either move
            // finds its new operand ready
            if (sum == target_x) begin
               res_found_in = 1'b1;
               res_a_in     = a_ff;
               res_b_in     = b_ff;
               state_in     = S_EMIT;
            end else if (sum < target_x) begin
               i_in = i_inc;
               a_in = first_rd_data;
               if (i_inc == n_ff) begin
                  res_found_in = 1'b0;
                  res_a_in     = '0;
                  res_b_in     = '0;
                  state_in     = S_EMIT;
               end
            end else begin
               j_in = j_dec;
               b_in = second_rd_data;
               if (j_dec == '0) begin
                  res_found_in = 1'b0;
                  res_a_in     = '0;
                  res_b_in     = '0;
                  state_in     = S_EMIT;
               end
            end
         end
         S_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_found_in  = res_found_ff;
               rsp_first_in  = res_a_ff;
               rsp_second_in = res_b_ff;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // next read addresses follow the pointers just chosen; out-of-range reads
   // are never used
   always_comb begin
      if (state_ff == S_IDLE) begin
         rd1_ptr = '0;
         rd2_ptr = query.size - SIZE_W'(1);
      end else begin
         rd1_ptr = i_in + SIZE_W'(1);
         rd2_ptr = j_in - SIZE_W'(2);
      end
   end

   assign first_rd_addr  = rd1_ptr[ADDR_W-1:0];
   assign second_rd_addr = rd2_ptr[ADDR_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      i_ff          <= i_in;
      j_ff          <= j_in;
      n_ff          <= n_in;
      target_ff     <= target_in;
      a_ff          <= a_in;
      b_ff          <= b_in;
      res_found_ff  <= res_found_in;
      res_a_ff      <= res_a_in;
      res_b_ff      <= res_b_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_first_ff  <= rsp_first_in;
      rsp_second_ff <= rsp_second_in;
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_found  = rsp_found_ff;
   assign rsp_first  = rsp_first_ff;
   assign rsp_second = rsp_second_ff;

endmodule

// ===== hdl/pair_sum_two_pointer_walk.sv =====
// ---------------------------------------------------------------------------
// pair_sum_two_pointer_walk
// Pair-sum search over two sorted sets held in RAM, by a two-pointer walk.
// ---------------------------------------------------------------------------
// Channels: req_ carries loads and queries (kind on req_tuser), rsp_ carries
// one result per query, csr_ writes set_size (reset value 1, clamped to 1024).
// Load each set entry by entry in ascending order before querying; a query
// over entries never loaded returns undefined values.
// Each load transfer makes one RAM write. A query walks one pointer step per
// cycle, both RAMs read every cycle with the next candidate of each pointer
// prefetched; a set_size of zero skips the walk and answers not found. One
// request is in work at a time.
// The result sits in an output register; a following load is taken while it
// waits. A finished query holds while rsp_tready is low and req_tready stays
// low until its result moves into the output register.
// Reset clears control state and sets set_size to 1; RAM contents are left
// as they are.
// ---------------------------------------------------------------------------
module pair_sum_two_pointer_walk (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // [9:0] index, [41:10] value, [47:42] zero
   input  logic [1:0]  req_tuser,   // [1:0] kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // [31:0] first_value, [63:32] second_value
   output logic        rsp_tuser,   // [0] found
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [10:0] csr_data     // [10:0] set_size
);
   import psw_pkg::*;

   logic [SIZE_W-1:0] set_size_ff, set_size_in;
   logic [SIZE_W-1:0] size_clamped;
   logic              req_xfer;
   logic              busy;
   query_type         query;
   logic [ADDR_W-1:0] req_index;
   logic [DATA_W-1:0] req_value;
   logic              first_we, second_we;
   logic [ADDR_W-1:0] first_rd_addr, second_rd_addr;
   logic [DATA_W-1:0] first_rd_data, second_rd_data;
   logic              rsp_found;
   logic [DATA_W-1:0] rsp_first, rsp_second;

   assign csr_ready   = 1'b1;
   assign set_size_in = (csr_valid) ? csr_data : set_size_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         set_size_ff <= SIZE_W'(1);
      end else begin
         set_size_ff <= set_size_in;
      end
   end

   assign size_clamped = (set_size_ff > MAX_SIZE) ? MAX_SIZE : set_size_ff;

   assign req_tready = ~busy;
   assign req_xfer   = req_tvalid & req_tready;
   assign req_index  = req_tdata[ADDR_W-1:0];
   assign req_value  = req_tdata[ADDR_W+DATA_W-1:ADDR_W];

   always_comb begin
      first_we  = 1'b0;
      second_we = 1'b0;
      query     = '{start: 1'b0, target: req_value, size: size_clamped};
      case (req_tuser)
         KIND_LOAD_FIRST:  first_we    = req_xfer;
         KIND_LOAD_SECOND: second_we   = req_xfer;
         KIND_QUERY:       query.start = req_xfer;
         default: ;
      endcase
   end

   psw_ram #(.WIDTH(DATA_W), .DEPTH(MAX_SET)) u_first_ram (
      .clock   (clock),
      .wr_en   (first_we),
      .wr_addr (req_index),
      .wr_data (req_value),
      .rd_addr (first_rd_addr),
      .rd_data (first_rd_data)
   );

   psw_ram #(.WIDTH(DATA_W), .DEPTH(MAX_SET)) u_second_ram (
      .clock   (clock),
      .wr_en   (second_we),
      .wr_addr (req_index),
      .wr_data (req_value),
      .rd_addr (second_rd_addr),
      .rd_data (second_rd_data)
   );

   psw_walk u_walk (
      .clock          (clock),
      .reset          (reset),
      .query          (query),
      .busy           (busy),
      .first_rd_addr  (first_rd_addr),
      .first_rd_data  (first_rd_data),
      .second_rd_addr (second_rd_addr),
      .second_rd_data (second_rd_data),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_found      (rsp_found),
      .rsp_first      (rsp_first),
      .rsp_second     (rsp_second)
   );

   assign rsp_tdata = {rsp_second, rsp_first};
   assign rsp_tuser = rsp_found;

endmodule

// ===== tb/pair_sum_two_pointer_walk_checker.sv =====
// ----------------------------------------------------------------------------
// pair_sum_two_pointer_walk_checker
// Watches the request, result and set-size channels of the pair-sum block,
// keeps its own copy of both sets, predicts each query's answer by walking
// the two pointers itself, and compares every result transfer field by field.
// ----------------------------------------------------------------------------
module pair_sum_two_pointer_walk_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [47:0] req_tdata,   // [9:0] index, [41:10] value, [47:42] zero
   input  logic [1:0]  req_tuser,   // [1:0] kind
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [63:0] rsp_tdata,   // [31:0] first_value, [63:32] second_value
   input  logic        rsp_tuser,   // [0] found
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [10:0] csr_data,    // [10:0] set_size
   output int          mismatches,
   output int          awaited
);
   timeunit 1ns;
   timeprecision 1ps;

   import psw_pkg::*;

   typedef struct packed {
      logic        found;
      logic [31:0] first_value;
      logic [31:0] second_value;
   } pair_match_type;

   logic [31:0]       first_entries  [MAX_SET];
   logic [31:0]       second_entries [MAX_SET];
   logic [SIZE_W-1:0] set_size_q;
   pair_match_type    pending_answers [$];
   pair_match_type    oldest;

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t ns: mismatch on %s: got %h, want %h", $time, what, got, want);
      mismatches++;
   endtask

   // Two-pointer walk over the current contents; sums kept at 33 bits.
   function automatic pair_match_type walk_for_target(input logic [31:0] target);
      pair_match_type          answer;
      int unsigned             n;
      int unsigned             lo;
      int unsigned             hi;
      logic                    done;
      logic signed [32:0]      total;
      logic signed [32:0]      goal;
      answer = '0;
      n      = set_size_q;
      if (n > MAX_SET)
         n = MAX_SET;
      lo   = 0;
      hi   = n;
      done = 1'b0;
      goal = {target[31], target};
      while (!done && lo < n && hi > 0) begin
         total = {first_entries[lo][31], first_entries[lo]}
               + {second_entries[hi-1][31], second_entries[hi-1]};
         if (total == goal) begin
            answer.found        = 1'b1;
            answer.first_value  = first_entries[lo];
            answer.second_value = second_entries[hi-1];
            done                = 1'b1;
         end else if (total < goal) begin
            lo++;
         end else begin
            hi--;
         end
      end
      return answer;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         set_size_q = SIZE_W'(1);
         mismatches = 0;
         pending_answers.delete();
         awaited <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_answers.size() == 0) begin
               report_mismatch("result with nothing awaited", rsp_tdata[31:0], 32'd0);
            end else begin
               oldest = pending_answers.pop_front();
               if (rsp_tuser !== oldest.found)
                  report_mismatch("found", {31'd0, rsp_tuser}, {31'd0, oldest.found});
               if (rsp_tdata[31:0] !== oldest.first_value)
                  report_mismatch("first_value", rsp_tdata[31:0], oldest.first_value);
               if (rsp_tdata[63:32] !== oldest.second_value)
                  report_mismatch("second_value", rsp_tdata[63:32], oldest.second_value);
            end
         end
         if (csr_valid && csr_ready)
            set_size_q = csr_data;
         if (req_tvalid && req_tready) begin
            case (req_tuser)
               KIND_LOAD_FIRST:  first_entries[req_tdata[9:0]]  = req_tdata[41:10];
               KIND_LOAD_SECOND: second_entries[req_tdata[9:0]] = req_tdata[41:10];
               KIND_QUERY:       pending_answers.push_back(walk_for_target(req_tdata[41:10]));
               default:          ;
            endcase
         end
         awaited <= pending_answers.size();
      end
   end

endmodule

// ===== tb/pair_sum_two_pointer_walk_tb.sv =====
// ----------------------------------------------------------------------------
// pair_sum_two_pointer_walk_tb
// Drives loads, queries and set-size writes into the pair-sum block: a short
// directed run over sign, overflow and saturating-size corners, then random
// small sets with matching and near-miss targets under varying back-pressure.
// ----------------------------------------------------------------------------
module pair_sum_two_pointer_walk_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import psw_pkg::*;

   localparam logic [1:0] KIND_UNUSED = 2'd3;
   localparam int RANDOM_ITEMS = 265;
   localparam int HOLD_CYCLES  = 500;
   localparam int LOAD_SETTLE  = 8;
   localparam int TAIL_CYCLES  = 2100;
   localparam int STALL_LIMIT  = 20000;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata  = '0;
   logic [1:0]  req_tuser  = KIND_LOAD_FIRST;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [10:0] csr_data   = '0;

   int mismatches;
   int awaited;
   int tx_idle_pct   = 11;
   int rx_idle_pct   = 70;
   int hold_asks     = 0;
   int hold_taken    = 0;
   int hold_left     = 0;
   int quiet_cycles  = 0;
   int items_offered = 0;

   // what has been loaded, only to steer target choice
   logic [31:0] first_copy  [MAX_SET];
   logic [31:0] second_copy [MAX_SET];

   pair_sum_two_pointer_walk u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   pair_sum_two_pointer_walk_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .mismatches (mismatches),
      .awaited    (awaited)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Result side: random stalls, plus a long hold-off on request.
   always @(posedge clock) begin
      if (hold_asks != hold_taken) begin
         hold_taken = hold_asks;
         hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("pair_sum_two_pointer_walk regression: fail");
            $finish;
         end
      end
   end

   task automatic offer(input logic [1:0] kind, input logic [9:0] index,
                        input logic [31:0] value);
      if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {6'd0, value, index};
      do @(posedge clock); while (!req_tready);
      case (kind)
         KIND_LOAD_FIRST:  first_copy[index]  = value;
         KIND_LOAD_SECOND: second_copy[index] = value;
         default:          ;
      endcase
      if (kind != KIND_UNUSED)
         items_offered++;
   endtask

   // Wait for every awaited result, then let any trailing load land.
   task automatic settle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (awaited != 0);
      repeat (LOAD_SETTLE) @(posedge clock);
   endtask

   task automatic write_set_size(input logic [10:0] size);
      settle();
      csr_valid <= 1'b1;
      csr_data  <= size;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic load_sorted(input logic [1:0] kind, input int count,
                              input longint base, input int unsigned stride);
      longint v;
      v = base;
      for (int k = 0; k < count; k++) begin
         v = v + longint'($urandom_range(0, stride));
         if (v > 64'sd2147483647)
            v = 64'sd2147483647;
         offer(kind, k[9:0], v[31:0]);
      end
   endtask

   task automatic load_set(input logic [1:0] kind, input int count);
      case ($urandom_range(0, 3))
         0: load_sorted(kind, count, longint'($urandom_range(0, 100)) - 50, 6);
         1: load_sorted(kind, count, -64'sd2147483648, 1 << 20);
         2: load_sorted(kind, count, longint'($signed($urandom())), 1 << 24);
         default: load_sorted(kind, count,
                              64'sd2147483647 - longint'($urandom_range(0, 100)), 3);
      endcase
   endtask

   function automatic logic [31:0] pick_target(input int n);
      int unsigned r;
      int unsigned a;
      int unsigned b;
      r = $urandom_range(0, 99);
      if (n == 0 || r >= 85)
         return $urandom();
      a = $urandom_range(0, n - 1);
      b = $urandom_range(0, n - 1);
      if (r < 65)
         return first_copy[a] + second_copy[b];
      return first_copy[a] + second_copy[b]
             + (($urandom_range(0, 1) == 0) ? 32'd1 : 32'hffff_ffff);
   endfunction

   task automatic run_queries(input int n, input int count);
      int unsigned r;
      for (int k = 0; k < count; k++) begin
         r = $urandom_range(0, 99);
         if (r < 80)
            offer(KIND_QUERY, 10'($urandom_range(0, 1023)), pick_target(n));
         else if (r < 92)
            offer(($urandom_range(0, 1) == 0) ? KIND_LOAD_FIRST : KIND_LOAD_SECOND,
                  10'($urandom_range(0, 1023)), $urandom());
         else
            offer(KIND_UNUSED, 10'($urandom_range(0, 1023)), $urandom());
      end
   endtask

   initial begin
      int          phase;
      int          n;
      int          start;
      int          span;
      int          queries;
      logic [10:0] size;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // empty sets: no entry is compared, always not found
      write_set_size(11'd0);
      offer(KIND_QUERY, 10'd0, 32'd0);
      offer(KIND_QUERY, 10'h3ff, 32'h8000_0000);
      offer(KIND_UNUSED, 10'h155, 32'hdead_beef);

      // one entry each; sums that only match if wrapped to 32 bits, and one exact match
      write_set_size(11'd1);
      offer(KIND_LOAD_FIRST, 10'd0, 32'h8000_0000);
      offer(KIND_LOAD_SECOND, 10'd0, 32'h8000_0000);
      offer(KIND_QUERY, 10'd0, 32'd0);
      offer(KIND_QUERY, 10'd0, 32'h8000_0000);
      offer(KIND_LOAD_FIRST, 10'd0, 32'h7fff_ffff);
      offer(KIND_LOAD_SECOND, 10'd0, 32'd1);
      offer(KIND_QUERY, 10'd0, 32'h8000_0000);
      offer(KIND_LOAD_SECOND, 10'd0, 32'h8000_0000);
      offer(KIND_QUERY, 10'd0, 32'hffff_ffff);
      offer(KIND_QUERY, 10'd0, 32'h7fff_ffff);

      write_set_size(11'd2);
      offer(KIND_LOAD_FIRST, 10'd0, 32'hffff_fffb);
      offer(KIND_LOAD_FIRST, 10'd1, 32'h7fff_ffff);
      offer(KIND_LOAD_SECOND, 10'd0, 32'h8000_0000);
      offer(KIND_LOAD_SECOND, 10'd1, 32'd3);
      offer(KIND_QUERY, 10'd0, 32'hffff_fffe);
      offer(KIND_QUERY, 10'd0, 32'hffff_ffff);
      offer(KIND_QUERY, 10'd0, 32'h8000_0002);

      // saturating size: only the two ends are loaded, the pair sits at the first step
      write_set_size(11'h7ff);
      offer(KIND_LOAD_FIRST, 10'd0, 32'h8000_0000);
      offer(KIND_LOAD_SECOND, 10'h3ff, 32'h7fff_ffff);
      offer(KIND_QUERY, 10'd0, 32'hffff_ffff);
      write_set_size(MAX_SIZE);
      offer(KIND_QUERY, 10'd0, 32'hffff_ffff);

      start = items_offered;
      phase = 0;
      span  = 0;
      while (span < RANDOM_ITEMS) begin
         if (span < 100) begin
            tx_idle_pct = 11;
            rx_idle_pct = 70;
         end else if (span < 200) begin
            tx_idle_pct = 70;
            rx_idle_pct = 11;
         end else begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
         end
         case ($urandom_range(0, 19))
            0:       size = 11'd0;
            1:       size = 11'($urandom_range(MAX_SET + 1, 2047));
            2:       size = 11'($urandom_range(17, 32));
            default: size = 11'($urandom_range(1, 16));
         endcase
         if (phase == 2)
            size = 11'd4;
         n = (size > MAX_SIZE) ? MAX_SET : int'(size);
         write_set_size(size);
         queries = $urandom_range(3, 10);
         if (size > MAX_SIZE) begin
            offer(KIND_LOAD_FIRST, 10'd0, $urandom());
            offer(KIND_LOAD_SECOND, 10'(MAX_SET - 1), $urandom());
            offer(KIND_QUERY, 10'd0, first_copy[0] + second_copy[MAX_SET-1]);
            queries = 0;
         end else if (phase % 5 == 4) begin
            for (int k = 0; k < n; k++) begin
               offer(KIND_LOAD_FIRST, k[9:0], $urandom());
               offer(KIND_LOAD_SECOND, k[9:0], $urandom());
            end
         end else begin
            load_set(KIND_LOAD_FIRST, n);
            load_set(KIND_LOAD_SECOND, n);
         end
         // block the result side while queries keep coming, so the input backs up
         if (phase == 2) begin
            hold_asks++;
            queries = 10;
         end
         run_queries(n, queries);
         phase++;
         span = items_offered - start;
      end

      settle();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0 && awaited == 0)
         $display("pair_sum_two_pointer_walk regression: pass");
      else
         $display("pair_sum_two_pointer_walk regression: fail");
      $finish;
   end

endmodule
